// ----- rtl/mag_cal_pkg.sv -----
// Shared widths, register indexes, reset values and types of the magnetometer calibration block.
`timescale 1ns / 1ps

package mag_cal_pkg;

  localparam int unsigned COEF_FRAC_BITS = 14;
  localparam int unsigned OUT_FRAC_BITS  = 4;
  localparam int unsigned ADJ_FRAC_BITS  = 8;

  localparam int unsigned RAW_W     = 16;
  localparam int unsigned ADJ_W     = 8;
  localparam int unsigned FAC_W     = ADJ_W + 1;
  localparam int unsigned HARD_W    = 16;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned MAT_W     = 3 * COEF_W;
  localparam int unsigned FIELD_W   = 24;
  localparam int unsigned BODY_W    = 26;
  localparam int unsigned PROD_W    = COEF_W + BODY_W;
  localparam int unsigned ACC_W     = PROD_W + 2;
  localparam int unsigned RND_SHIFT = ADJ_FRAC_BITS + COEF_FRAC_BITS - OUT_FRAC_BITS;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = MAT_W;

  localparam logic [CFG_IDX_W-1:0] REG_SENS_ADJ_X   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SENS_ADJ_Y   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SENS_ADJ_Z   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HARD_IRON_X  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_HARD_IRON_Y  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_HARD_IRON_Z  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_DIAG  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_OFFD  = CFG_IDX_W'(7);

  localparam logic [FAC_W-1:0]  FAC_OFFSET    = FAC_W'(128);
  localparam logic [ADJ_W-1:0]  SENS_ADJ_RST  = ADJ_W'(128);
  localparam logic [MAT_W-1:0]  MAT_DIAG_RST  = 48'h4000_4000_4000;
  localparam logic [MAT_W-1:0]  MAT_OFFD_RST  = '0;

  typedef struct packed {
    logic [ADJ_W-1:0]         adj_x;
    logic [ADJ_W-1:0]         adj_y;
    logic [ADJ_W-1:0]         adj_z;
    logic signed [HARD_W-1:0] hard_x;
    logic signed [HARD_W-1:0] hard_y;
    logic signed [HARD_W-1:0] hard_z;
    logic [MAT_W-1:0]         mat_diag;
    logic [MAT_W-1:0]         mat_offd;
  } cfg_t;

  typedef struct packed {
    logic                     ovf;
    logic signed [BODY_W-1:0] bx;
    logic signed [BODY_W-1:0] by;
    logic signed [BODY_W-1:0] bz;
  } body_t;

endpackage

// ----- rtl/mag_cal_if.sv -----
// Handshake interfaces for the sample, field and configuration channels.
`timescale 1ns / 1ps

interface mag_sample_if;
  import mag_cal_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    sample_ready;
  logic                    sample_overflow;
  logic signed [RAW_W-1:0] raw_x;
  logic signed [RAW_W-1:0] raw_y;
  logic signed [RAW_W-1:0] raw_z;

  modport source (output valid, sample_ready, sample_overflow, raw_x, raw_y, raw_z,
                  input ready);
  modport sink (input valid, sample_ready, sample_overflow, raw_x, raw_y, raw_z,
                output ready);
endinterface

interface mag_field_if;
  import mag_cal_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] field_x;
  logic signed [FIELD_W-1:0] field_y;
  logic signed [FIELD_W-1:0] field_z;
  logic                      was_overflow;

  modport source (output valid, field_x, field_y, field_z, was_overflow, input ready);
  modport sink (input valid, field_x, field_y, field_z, was_overflow, output ready);
endinterface

interface mag_cfg_if;
  import mag_cal_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/mag_cal_cfg.sv -----
// Configuration register file: sensitivity bytes, hard-iron offsets and soft-iron matrix.
`timescale 1ns / 1ps

module mag_cal_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  mag_cfg_if.sink            cfg_i,
  output mag_cal_pkg::cfg_t  cfg_o
);
  import mag_cal_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SENS_ADJ_X:  cfg_d.adj_x    = cfg_i.data[ADJ_W-1:0];
        REG_SENS_ADJ_Y:  cfg_d.adj_y    = cfg_i.data[ADJ_W-1:0];
        REG_SENS_ADJ_Z:  cfg_d.adj_z    = cfg_i.data[ADJ_W-1:0];
        REG_HARD_IRON_X: cfg_d.hard_x   = $signed(cfg_i.data[HARD_W-1:0]);
        REG_HARD_IRON_Y: cfg_d.hard_y   = $signed(cfg_i.data[HARD_W-1:0]);
        REG_HARD_IRON_Z: cfg_d.hard_z   = $signed(cfg_i.data[HARD_W-1:0]);
        REG_MATRIX_DIAG: cfg_d.mat_diag = cfg_i.data[MAT_W-1:0];
        REG_MATRIX_OFFD: cfg_d.mat_offd = cfg_i.data[MAT_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adj_x    <= SENS_ADJ_RST;
      cfg_q.adj_y    <= SENS_ADJ_RST;
      cfg_q.adj_z    <= SENS_ADJ_RST;
      cfg_q.hard_x   <= '0;
      cfg_q.hard_y   <= '0;
      cfg_q.hard_z   <= '0;
      cfg_q.mat_diag <= MAT_DIAG_RST;
      cfg_q.mat_offd <= MAT_OFFD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/mag_cal_adjust.sv -----
// Front pipeline: sensitivity scaling, body-frame remap and hard-iron removal.
`timescale 1ns / 1ps

module mag_cal_adjust (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mag_cal_pkg::cfg_t  cfg_i,
  mag_sample_if.sink         sample_i,
  output logic               body_valid_o,
  input  logic               body_ready_i,
  output mag_cal_pkg::body_t body_o
);
  import mag_cal_pkg::*;

  logic                     v1_q, v2_q;
  logic                     adv1, adv2;
  logic                     ovf1_q;
  logic signed [BODY_W-1:0] sx_q, sy_q, sz_q;
  logic signed [BODY_W-1:0] sx_d, sy_d, sz_d;
  logic signed [BODY_W-1:0] hx, hy, hz;
  body_t                    body_q, body_d;

  function automatic logic signed [BODY_W-1:0] scale_axis(
    input logic signed [RAW_W-1:0] raw,
    input logic [ADJ_W-1:0]        adj,
    input logic                    zero
  );
    logic signed [BODY_W-1:0] r;
    logic signed [BODY_W-1:0] f;
    r = zero ? '0 : BODY_W'(raw);
    f = BODY_W'({1'b0, adj} + FAC_OFFSET);
    return r * f;
  endfunction

  assign adv2           = !v2_q || body_ready_i;
  assign adv1           = !v1_q || adv2;
  assign sample_i.ready = adv1;
  assign body_valid_o   = v2_q;
  assign body_o         = body_q;

  always_comb begin
    sx_d = scale_axis(sample_i.raw_x, cfg_i.adj_x, sample_i.sample_overflow);
    sy_d = scale_axis(sample_i.raw_y, cfg_i.adj_y, sample_i.sample_overflow);
    sz_d = scale_axis(sample_i.raw_z, cfg_i.adj_z, sample_i.sample_overflow);
  end

  always_comb begin
    hx = BODY_W'(cfg_i.hard_x) <<< ADJ_FRAC_BITS;
    hy = BODY_W'(cfg_i.hard_y) <<< ADJ_FRAC_BITS;
    hz = BODY_W'(cfg_i.hard_z) <<< ADJ_FRAC_BITS;
    body_d.ovf = ovf1_q;
    body_d.bx  = -sy_q - hx;
    body_d.by  = sz_q - hy;
    body_d.bz  = -sx_q - hz;
  end

  // drop beats without new data at the first stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= sample_i.valid && sample_i.sample_ready;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      ovf1_q <= sample_i.sample_overflow;
      sx_q   <= sx_d;
      sy_q   <= sy_d;
      sz_q   <= sz_d;
    end
    if (adv2) begin
      body_q <= body_d;
    end
  end

endmodule

// ----- rtl/mag_cal_matrix.sv -----
// Back pipeline: soft-iron matrix products, row sums, rounding and saturation.
`timescale 1ns / 1ps

module mag_cal_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mag_cal_pkg::cfg_t  cfg_i,
  input  logic               body_valid_i,
  output logic               body_ready_o,
  input  mag_cal_pkg::body_t body_i,
  mag_field_if.source        field_o
);
  import mag_cal_pkg::*;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (RND_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'((2 ** (FIELD_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO   = ~SAT_HI;

  logic                      v3_q, v4_q, vo_q;
  logic                      adv3, adv4, advo;
  logic                      ovf3_q, ovf4_q, ovfo_q;
  logic signed [COEF_W-1:0]  coef [3][3];
  logic signed [BODY_W-1:0]  vec [3];
  logic signed [PROD_W-1:0]  prod_d [3][3];
  logic signed [PROD_W-1:0]  prod_q [3][3];
  logic signed [ACC_W-1:0]   acc_d [3];
  logic signed [ACC_W-1:0]   acc_q [3];
  logic signed [FIELD_W-1:0] res_d [3];
  logic signed [FIELD_W-1:0] res_q [3];

  function automatic logic signed [FIELD_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    s = a >>> RND_SHIFT;
    priority if (s > SAT_HI) begin
      return SAT_HI[FIELD_W-1:0];
    end else if (s < SAT_LO) begin
      return SAT_LO[FIELD_W-1:0];
    end else begin
      return s[FIELD_W-1:0];
    end
  endfunction

  assign advo         = !vo_q || field_o.ready;
  assign adv4         = !v4_q || advo;
  assign adv3         = !v3_q || adv4;
  assign body_ready_o = adv3;

  assign field_o.valid        = vo_q;
  assign field_o.field_x      = res_q[0];
  assign field_o.field_y      = res_q[1];
  assign field_o.field_z      = res_q[2];
  assign field_o.was_overflow = ovfo_q;

  always_comb begin
    coef[0][0] = $signed(cfg_i.mat_diag[3*COEF_W-1 -: COEF_W]);
    coef[1][1] = $signed(cfg_i.mat_diag[2*COEF_W-1 -: COEF_W]);
    coef[2][2] = $signed(cfg_i.mat_diag[COEF_W-1 -: COEF_W]);
    coef[0][1] = $signed(cfg_i.mat_offd[3*COEF_W-1 -: COEF_W]);
    coef[0][2] = $signed(cfg_i.mat_offd[2*COEF_W-1 -: COEF_W]);
    coef[1][2] = $signed(cfg_i.mat_offd[COEF_W-1 -: COEF_W]);
    coef[1][0] = coef[0][1];
    coef[2][0] = coef[0][2];
    coef[2][1] = coef[1][2];
    vec[0] = body_i.bx;
    vec[1] = body_i.by;
    vec[2] = body_i.bz;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = PROD_W'(coef[i][j]) * PROD_W'(vec[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_d[i] = ACC_W'(prod_q[i][0]) + ACC_W'(prod_q[i][1]) + ACC_W'(prod_q[i][2]) + RND_HALF;
      res_d[i] = round_sat(acc_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv3) begin
        v3_q <= body_valid_i;
      end
      if (adv4) begin
        v4_q <= v3_q;
      end
      if (advo) begin
        vo_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      ovf3_q <= body_i.ovf;
      prod_q <= prod_d;
    end
    if (adv4) begin
      ovf4_q <= ovf3_q;
      acc_q  <= acc_d;
    end
    if (advo) begin
      ovfo_q <= ovf4_q;
      res_q  <= res_d;
    end
  end

endmodule

// ----- rtl/magnetometer_calibration.sv -----
// Magnetometer calibration: pipelined scaling, remap, offset and soft-iron correction.
`timescale 1ns / 1ps

// Takes one three-axis sample beat per clock while the output is not held and returns
// the calibrated body-frame field (sensitivity multiply, remap and offset, nine
// coefficient multiplies, row sums, rounding and saturation each own one register stage).
// Sustained rate is one beat per cycle while field_o.ready is high; each stage advances
// independently, so bubbles are squeezed out and a held output beat stalls only the
// stages behind it. Beats with sample_ready low are consumed and produce no result.
// Configuration writes are accepted every cycle; write them while the pipeline is empty.
module magnetometer_calibration (
  input  logic       clk_i,
  input  logic       rst_ni,
  mag_cfg_if.sink    cfg_i,
  mag_sample_if.sink sample_i,
  mag_field_if.source field_o
);
  import mag_cal_pkg::*;

  cfg_t  cfg;
  body_t body;
  logic  body_valid;
  logic  body_ready;

  mag_cal_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  mag_cal_adjust u_adjust (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .sample_i     (sample_i),
    .body_valid_o (body_valid),
    .body_ready_i (body_ready),
    .body_o       (body)
  );

  mag_cal_matrix u_matrix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .body_valid_i (body_valid),
    .body_ready_o (body_ready),
    .body_i       (body),
    .field_o      (field_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench of the magnetometer calibration block with its own field predictor.
`timescale 1ns / 1ps

module testbench;
  import mag_cal_pkg::*;

  typedef struct packed {
    logic                    rdy;
    logic                    ovf;
    logic signed [RAW_W-1:0] x;
    logic signed [RAW_W-1:0] y;
    logic signed [RAW_W-1:0] z;
  } sample_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] fx;
    logic signed [FIELD_W-1:0] fy;
    logic signed [FIELD_W-1:0] fz;
    logic                      ovf;
  } field_t;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam longint FIELD_MAX = 64'sd8388607;
  localparam longint FIELD_MIN = -64'sd8388608;

  logic clk_i;
  logic rst_ni;

  mag_cfg_if    cfg_bus ();
  mag_sample_if smp_bus ();
  mag_field_if  fld_bus ();

  magnetometer_calibration u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .sample_i (smp_bus),
    .field_o  (fld_bus)
  );

  logic        [ADJ_W-1:0]  adj_cfg  [3];
  logic signed [HARD_W-1:0] hard_cfg [3];
  logic        [MAT_W-1:0]  diag_cfg;
  logic        [MAT_W-1:0]  offd_cfg;

  field_t      pending_fields [$];
  bit          failed;
  bit          idle_en;
  int unsigned cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint coef_at(logic [MAT_W-1:0] mat, int lsb);
    return longint'($signed(mat[lsb +: COEF_W]));
  endfunction

  function automatic logic signed [FIELD_W-1:0] round_sat(longint acc);
    longint r;
    r = (acc + (longint'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    if (r > FIELD_MAX) r = FIELD_MAX;
    if (r < FIELD_MIN) r = FIELD_MIN;
    return r[FIELD_W-1:0];
  endfunction

  function automatic field_t calibrate_field(sample_t s);
    longint raw  [3];
    longint sens [3];
    longint body [3];
    longint m    [3][3];
    longint acc  [3];
    field_t f;
    raw[0] = s.ovf ? 0 : longint'($signed(s.x));
    raw[1] = s.ovf ? 0 : longint'($signed(s.y));
    raw[2] = s.ovf ? 0 : longint'($signed(s.z));
    for (int i = 0; i < 3; i++) sens[i] = raw[i] * (longint'(adj_cfg[i]) + 128);
    body[0] = -sens[1];
    body[1] = sens[2];
    body[2] = -sens[0];
    for (int i = 0; i < 3; i++) body[i] -= longint'(hard_cfg[i]) <<< ADJ_FRAC_BITS;
    m[0][0] = coef_at(diag_cfg, 32);
    m[1][1] = coef_at(diag_cfg, 16);
    m[2][2] = coef_at(diag_cfg, 0);
    m[0][1] = coef_at(offd_cfg, 32);
    m[1][0] = m[0][1];
    m[0][2] = coef_at(offd_cfg, 16);
    m[2][0] = m[0][2];
    m[1][2] = coef_at(offd_cfg, 0);
    m[2][1] = m[1][2];
    for (int i = 0; i < 3; i++) begin
      acc[i] = 0;
      for (int j = 0; j < 3; j++) acc[i] += m[i][j] * body[j];
    end
    f.fx  = round_sat(acc[0]);
    f.fy  = round_sat(acc[1]);
    f.fz  = round_sat(acc[2]);
    f.ovf = s.ovf;
    return f;
  endfunction

  task automatic check_field(string what, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    field_t want;
    if (rst_ni && fld_bus.valid && fld_bus.ready) begin
      if (pending_fields.size() == 0) begin
        $display("%0t: unexpected field beat, expected none, actual x=%0d y=%0d z=%0d ovf=%0b",
                 $time, fld_bus.field_x, fld_bus.field_y, fld_bus.field_z,
                 fld_bus.was_overflow);
        failed = 1'b1;
      end else begin
        want = pending_fields.pop_front();
        check_field("field_x", want.fx, fld_bus.field_x);
        check_field("field_y", want.fy, fld_bus.field_y);
        check_field("field_z", want.fz, fld_bus.field_z);
        check_field("was_overflow", want.ovf, fld_bus.was_overflow);
      end
    end
  end

  initial begin
    int stall;
    fld_bus.ready = 1'b0;
    forever begin
      stall = idle_en ? $urandom_range(0, 13) : 0;
      repeat (stall) begin
        @(negedge clk_i);
        fld_bus.ready <= 1'b0;
      end
      @(negedge clk_i);
      fld_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(fld_bus.valid && rst_ni));
    end
  end

  task automatic push_sample(sample_t s);
    int gap;
    gap = idle_en ? $urandom_range(0, 13) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      smp_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    smp_bus.valid           <= 1'b1;
    smp_bus.sample_ready    <= s.rdy;
    smp_bus.sample_overflow <= s.ovf;
    smp_bus.raw_x           <= s.x;
    smp_bus.raw_y           <= s.y;
    smp_bus.raw_z           <= s.z;
    do @(posedge clk_i); while (!smp_bus.ready);
    if (s.rdy) pending_fields.push_back(calibrate_field(s));
  endtask

  task automatic drain_fields();
    @(negedge clk_i);
    smp_bus.valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cal_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      REG_SENS_ADJ_X:  adj_cfg[0] = val[ADJ_W-1:0];
      REG_SENS_ADJ_Y:  adj_cfg[1] = val[ADJ_W-1:0];
      REG_SENS_ADJ_Z:  adj_cfg[2] = val[ADJ_W-1:0];
      REG_HARD_IRON_X: hard_cfg[0] = val[HARD_W-1:0];
      REG_HARD_IRON_Y: hard_cfg[1] = val[HARD_W-1:0];
      REG_HARD_IRON_Z: hard_cfg[2] = val[HARD_W-1:0];
      REG_MATRIX_DIAG: diag_cfg = val;
      REG_MATRIX_OFFD: offd_cfg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic write_all_regs(logic [ADJ_W-1:0] ax, logic [ADJ_W-1:0] ay,
                                logic [ADJ_W-1:0] az, logic [HARD_W-1:0] hx,
                                logic [HARD_W-1:0] hy, logic [HARD_W-1:0] hz,
                                logic [MAT_W-1:0] dg, logic [MAT_W-1:0] od);
    drain_fields();
    write_cal_reg(REG_SENS_ADJ_X, CFG_DATA_W'(ax));
    write_cal_reg(REG_SENS_ADJ_Y, CFG_DATA_W'(ay));
    write_cal_reg(REG_SENS_ADJ_Z, CFG_DATA_W'(az));
    write_cal_reg(REG_HARD_IRON_X, CFG_DATA_W'(hx));
    write_cal_reg(REG_HARD_IRON_Y, CFG_DATA_W'(hy));
    write_cal_reg(REG_HARD_IRON_Z, CFG_DATA_W'(hz));
    write_cal_reg(REG_MATRIX_DIAG, dg);
    write_cal_reg(REG_MATRIX_OFFD, od);
  endtask

  function automatic logic signed [RAW_W-1:0] rand_raw();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return RAW_W'($signed($urandom_range(0, 400)) - 200);
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef(int center, int spread);
    if ($urandom_range(0, 7) == 0) return COEF_W'($urandom);
    return COEF_W'(center + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic logic [ADJ_W-1:0] rand_adj();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return ADJ_W'($urandom);
    endcase
  endfunction

  function automatic logic [HARD_W-1:0] rand_hard();
    case ($urandom_range(0, 5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return HARD_W'($urandom);
      default: return HARD_W'($signed($urandom_range(0, 1000)) - 500);
    endcase
  endfunction

  task automatic test_reset_config();
    push_sample('{1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0});
    push_sample('{1'b1, 1'b0, 16'sh7fff, 16'sh8000, 16'sd1234});
    push_sample('{1'b1, 1'b0, 16'sh8000, 16'sh8000, 16'sh8000});
    push_sample('{1'b1, 1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    push_sample('{1'b0, 1'b1, 16'sh5555, 16'shaaaa, 16'sh7fff});
    push_sample('{1'b0, 1'b0, 16'sh1234, 16'sh8000, 16'sh0001});
    push_sample('{1'b1, 1'b1, 16'sh7fff, 16'sh8000, 16'sh7fff});
    push_sample('{1'b1, 1'b0, -16'sd1, 16'sd1, -16'sd1});
  endtask

  task automatic test_rounding_ties();
    write_all_regs(SENS_ADJ_RST, SENS_ADJ_RST, SENS_ADJ_RST, '0, '0, '0,
                   {16'h0001, 16'h0001, 16'h4000}, MAT_OFFD_RST);
    push_sample('{1'b1, 1'b0, 16'sd0, -16'sd512, 16'sd512});
    push_sample('{1'b1, 1'b0, 16'sd0, 16'sd512, -16'sd512});
    push_sample('{1'b1, 1'b0, 16'sd3, -16'sd1536, 16'sd1536});
    push_sample('{1'b1, 1'b0, 16'sd0, -16'sd511, 16'sd513});
  endtask

  task automatic test_extreme_config();
    write_all_regs(8'hff, 8'hff, 8'hff, 16'h7fff, 16'h8000, 16'h0000,
                   {16'h7fff, 16'h8000, 16'h7fff}, {16'h7fff, 16'h8000, 16'h7fff});
    push_sample('{1'b1, 1'b0, 16'sh8000, 16'sh7fff, 16'sh8000});
    push_sample('{1'b1, 1'b0, 16'sh7fff, 16'sh8000, 16'sh7fff});
    push_sample('{1'b1, 1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    write_all_regs(8'h00, 8'h00, 8'h00, 16'h8000, 16'h7fff, 16'hffff,
                   {16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000});
    push_sample('{1'b1, 1'b0, 16'sh8000, 16'sh8000, 16'sh8000});
    push_sample('{1'b1, 1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    write_all_regs(8'h7f, 8'h80, 8'hff, 16'h0001, 16'hffff, 16'h8000, '0, '0);
    push_sample('{1'b1, 1'b0, 16'sh7fff, 16'sh8000, 16'sh1234});
    push_sample('{1'b1, 1'b1, 16'sh0000, 16'sh0000, 16'sh0000});
  endtask

  task automatic test_random_phases();
    sample_t s;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_all_regs(rand_adj(), rand_adj(), rand_adj(), rand_hard(), rand_hard(), rand_hard(),
                     {rand_coef(16384, 2048), rand_coef(16384, 2048), rand_coef(16384, 2048)},
                     {rand_coef(0, 1024), rand_coef(0, 1024), rand_coef(0, 1024)});
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) idle_en = ~idle_en;
        s.rdy = ($urandom_range(0, 9) != 0);
        s.ovf = ($urandom_range(0, 7) == 0);
        s.x   = rand_raw();
        s.y   = rand_raw();
        s.z   = rand_raw();
        push_sample(s);
      end
    end
  endtask

  initial begin
    rst_ni                  = 1'b0;
    smp_bus.valid           = 1'b0;
    smp_bus.sample_ready    = 1'b0;
    smp_bus.sample_overflow = 1'b0;
    smp_bus.raw_x           = '0;
    smp_bus.raw_y           = '0;
    smp_bus.raw_z           = '0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = REG_SENS_ADJ_X;
    cfg_bus.data            = '0;
    failed                  = 1'b0;
    idle_en                 = 1'b1;
    cycle_cnt               = 0;
    for (int i = 0; i < 3; i++) begin
      adj_cfg[i]  = SENS_ADJ_RST;
      hard_cfg[i] = '0;
    end
    diag_cfg = MAT_DIAG_RST;
    offd_cfg = MAT_OFFD_RST;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_config();
    test_rounding_ties();
    test_extreme_config();
    test_random_phases();

    drain_fields();
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
